[rtl/qrgs_pkg.sv]
package qrgs_pkg;

  // angle datapath: Q2.30 values with headroom for the cordic gain
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int ANGLE_FRAC   = 30;

  localparam logic signed [CORDIC_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CORDIC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_COL0_ZERO = 2'd1;
  localparam logic [1:0] STATUS_DEPENDENT = 2'd2;

  // atan(2^-i) in Q2.30, exact table for the first ten steps
  function automatic logic signed [CORDIC_W-1:0] atan_q30(input int i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      0: begin
        a = 34'sd843314857;
      end
      1: begin
        a = 34'sd497837829;
      end
      2: begin
        a = 34'sd263043837;
      end
      3: begin
        a = 34'sd133525159;
      end
      4: begin
        a = 34'sd67021687;
      end
      5: begin
        a = 34'sd33543516;
      end
      6: begin
        a = 34'sd16775851;
      end
      7: begin
        a = 34'sd8388437;
      end
      8: begin
        a = 34'sd4194283;
      end
      9: begin
        a = 34'sd2097149;
      end
      default: begin
        a = CORDIC_W'(64'sd1 <<< (ANGLE_FRAC - i));
      end
    endcase
    return a;
  endfunction

  // magnitude of a two's complement word, -2^31 maps to 2^31
  function automatic logic [31:0] abs32(input logic [31:0] v);
    logic [31:0] r;
    r = v[31] ? (~v + 32'd1) : v;
    return r;
  endfunction

endpackage

[rtl/qrgs_isqrt.sv]
module qrgs_isqrt #(
  parameter int IN_W   = 64,
  parameter int SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);
  localparam int RW    = IN_W / 2;
  localparam int REM_W = RW + 3;

  logic              vld_q  [RW];
  logic [REM_W-1:0]  rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [IN_W-1:0]   rad_q  [RW];
  logic [SIDE_W-1:0] side_q [RW];

  // one root bit per stage
  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              vld_c;
    logic [REM_W-1:0]  rem_c;
    logic [RW-1:0]     root_c;
    logic [IN_W-1:0]   rad_c;
    logic [SIDE_W-1:0] side_c;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign rem_c  = '0;
      assign root_c = '0;
      assign rad_c  = rad_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign rem_c  = rem_q[k-1];
      assign root_c = root_q[k-1];
      assign rad_c  = rad_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign rem_sh = {rem_c[REM_W-3:0], rad_c[IN_W-1 -: 2]};
    assign trial  = {1'b0, root_c, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_c[RW-2:0], take};
        rad_q[k]  <= rad_c << 2;
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[RW-1];
  assign root_o  = root_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

[rtl/qrgs_div.sv]
module qrgs_div #(
  parameter int M_W    = 32,
  parameter int D_W    = 32,
  parameter int Q_W    = 25,
  parameter int SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [M_W-1:0]    mx_i,
  input  logic [M_W-1:0]    my_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    qx_o,
  output logic [Q_W-1:0]    qy_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int REM_W = D_W + 1;

  logic              vld_q  [Q_W];
  logic [REM_W-1:0]  remx_q [Q_W];
  logic [REM_W-1:0]  remy_q [Q_W];
  logic [Q_W-1:0]    qx_q   [Q_W];
  logic [Q_W-1:0]    qy_q   [Q_W];
  logic [D_W-1:0]    den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  // restoring division of (m << frac) by den, one quotient bit per stage, two lanes
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic              vld_c;
    logic [REM_W-1:0]  remx_c;
    logic [REM_W-1:0]  remy_c;
    logic [Q_W-1:0]    qx_c;
    logic [Q_W-1:0]    qy_c;
    logic [D_W-1:0]    den_c;
    logic [SIDE_W-1:0] side_c;
    logic [REM_W-1:0]  den_ext;
    logic              bx;
    logic              by;

    if (k == 0) begin : g_first
      assign vld_c  = valid_i;
      assign remx_c = REM_W'(mx_i);
      assign remy_c = REM_W'(my_i);
      assign qx_c   = '0;
      assign qy_c   = '0;
      assign den_c  = den_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[k-1];
      assign remx_c = {remx_q[k-1][REM_W-2:0], 1'b0};
      assign remy_c = {remy_q[k-1][REM_W-2:0], 1'b0};
      assign qx_c   = qx_q[k-1];
      assign qy_c   = qy_q[k-1];
      assign den_c  = den_q[k-1];
      assign side_c = side_q[k-1];
    end

    assign den_ext = {1'b0, den_c};
    assign bx      = (remx_c >= den_ext);
    assign by      = (remy_c >= den_ext);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        remx_q[k] <= bx ? (remx_c - den_ext) : remx_c;
        remy_q[k] <= by ? (remy_c - den_ext) : remy_c;
        qx_q[k]   <= {qx_c[Q_W-2:0], bx};
        qy_q[k]   <= {qy_c[Q_W-2:0], by};
        den_q[k]  <= den_c;
        side_q[k] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign qx_o    = qx_q[Q_W-1];
  assign qy_o    = qy_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[rtl/qrgs_cordic.sv]
module qrgs_cordic #(
  parameter int SIDE_W = 1
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [qrgs_pkg::CORDIC_W-1:0]    x_i,
  input  logic signed [qrgs_pkg::CORDIC_W-1:0]    y_i,
  input  logic signed [qrgs_pkg::CORDIC_W-1:0]    z_i,
  input  logic [SIDE_W-1:0]                       side_i,
  output logic                                    valid_o,
  output logic signed [qrgs_pkg::CORDIC_W-1:0]    z_o,
  output logic [SIDE_W-1:0]                       side_o
);
  import qrgs_pkg::*;

  localparam int W = CORDIC_W;
  localparam int N = CORDIC_STEPS;

  logic                vld_q  [N];
  logic signed [W-1:0] x_q    [N];
  logic signed [W-1:0] y_q    [N];
  logic signed [W-1:0] z_q    [N];
  logic [SIDE_W-1:0]   side_q [N];

  // vectoring mode, one micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [W-1:0] ATAN_I = atan_q30(i);
    logic                vld_c;
    logic signed [W-1:0] x_c;
    logic signed [W-1:0] y_c;
    logic signed [W-1:0] z_c;
    logic [SIDE_W-1:0]   side_c;
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;
    logic                pos;

    if (i == 0) begin : g_first
      assign vld_c  = valid_i;
      assign x_c    = x_i;
      assign y_c    = y_i;
      assign z_c    = z_i;
      assign side_c = side_i;
    end else begin : g_next
      assign vld_c  = vld_q[i-1];
      assign x_c    = x_q[i-1];
      assign y_c    = y_q[i-1];
      assign z_c    = z_q[i-1];
      assign side_c = side_q[i-1];
    end

    assign dx  = y_c >>> i;
    assign dy  = x_c >>> i;
    assign pos = !y_c[W-1] && (y_c != '0);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i]    <= pos ? (x_c + dx) : (x_c - dx);
        y_q[i]    <= pos ? (y_c - dy) : (y_c + dy);
        z_q[i]    <= pos ? (z_c + ATAN_I) : (z_c - ATAN_I);
        side_q[i] <= side_c;
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign z_o     = z_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

[rtl/qr_2x2_gram_schmidt.sv]
// channel    | direction | width | contents
// s_axis     | in        | 128   | one 2x2 matrix request
// m_axis     | out       | 288   | q, r, rotation angle, stretch, status
// cfg        | in        | 31    | stretch threshold, write only
//
// fully pipelined, one matrix per cycle unless the output stalls; the pipeline depth is set
// by the two 32-stage square roots, three (FRAC_BITS+1)-stage dividers/roots and the
// 30-stage cordic
// reset clears the valid bits and loads the threshold with 1.0
// a stalled output freezes the whole pipeline together, nothing is dropped
module qr_2x2_gram_schmidt #(
  parameter int FRAC_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // in_00, in_01, in_10, in_11 (32 bit each, lowest first)
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // q_00, q_01, q_10, q_11, r_00, r_01, r_11, rotation_angle, stretch, status, zero pad
  output logic [287:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i
);
  import qrgs_pkg::*;

  localparam int EW    = FRAC_BITS + 2;        // signed unit component
  localparam int QW    = FRAC_BITS + 1;        // unsigned quotient
  localparam int PW    = 32 + EW;              // input times unit component
  localparam int UV_W  = PW + 1 - FRAC_BITS;   // projection
  localparam int MW    = UV_W + EW;            // projection times unit component
  localparam int DW    = MW - FRAC_BITS + 1;   // residual before clip
  localparam int RAD_W = 2 * FRAC_BITS + 2;    // 1.0^2 - c^2
  localparam int SH    = ANGLE_FRAC - FRAC_BITS;

  localparam logic signed [EW-1:0]       ONE_E   = EW'(64'd1 << FRAC_BITS);
  localparam logic [RAD_W-1:0]           ONE_SQ  = RAD_W'(1) << (2 * FRAC_BITS);
  localparam logic signed [DW-1:0]       LIM_HI  = DW'(64'sd2147483648);
  localparam logic signed [DW-1:0]       LIM_LO  = DW'(-64'sd2147483648);
  localparam logic signed [UV_W-1:0]     I32_MAX = UV_W'(64'sd2147483647);
  localparam logic signed [UV_W-1:0]     I32_MIN = UV_W'(-64'sd2147483648);
  localparam logic signed [CORDIC_W-1:0] RND     =
    (SH > 0) ? CORDIC_W'(64'sd1 <<< (SH - 1)) : '0;

  // packed from the top bit down, so in_00 lands in the lowest word
  typedef struct packed {
    logic signed [31:0] d;
    logic signed [31:0] c;
    logic signed [31:0] b;
    logic signed [31:0] a;
  } mat_t;

  typedef struct packed {
    logic               sa;
    logic               sc;
    logic signed [31:0] b;
    logic signed [31:0] d;
    logic [31:0]        n1;
  } d1_t;

  typedef struct packed {
    logic signed [EW-1:0] e1x;
    logic signed [EW-1:0] e1y;
    logic signed [31:0]   b;
    logic signed [31:0]   d;
    logic [31:0]          n1;
    logic                 z1;
  } st3_t;

  typedef struct packed {
    logic signed [UV_W-1:0] uv;
    logic signed [EW-1:0]   e1x;
    logic signed [EW-1:0]   e1y;
    logic signed [31:0]     b;
    logic signed [31:0]     d;
    logic [31:0]            n1;
    logic                   z1;
  } st5_t;

  typedef struct packed {
    logic [31:0]            ax;
    logic [31:0]            ay;
    logic                   sx;
    logic                   sy;
    logic signed [UV_W-1:0] uv;
    logic signed [EW-1:0]   e1x;
    logic signed [EW-1:0]   e1y;
    logic [31:0]            n1;
    logic                   z1;
  } st7_t;

  typedef struct packed {
    logic                   sx;
    logic                   sy;
    logic signed [UV_W-1:0] uv;
    logic signed [EW-1:0]   e1x;
    logic signed [EW-1:0]   e1y;
    logic [31:0]            n1;
    logic [31:0]            n2;
    logic                   z1;
  } d2_t;

  typedef struct packed {
    logic signed [31:0] q00;
    logic signed [31:0] q01;
    logic signed [31:0] q10;
    logic signed [31:0] q11;
    logic [30:0]        r00;
    logic signed [31:0] r01;
    logic [30:0]        r11;
    logic [1:0]         status;
  } res_t;

  localparam int MAT_W = $bits(mat_t);
  localparam int D1_W  = $bits(d1_t);
  localparam int ST7_W = $bits(st7_t);
  localparam int D2_W  = $bits(d2_t);
  localparam int RES_W = $bits(res_t);

  // global advance: the pipeline moves unless a finished result waits
  logic pipe_en;
  logic out_vld_q;

  assign pipe_en       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = pipe_en;

  // threshold register
  logic [30:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage 1: squared norm of the first column
  mat_t        mat_d;
  logic [31:0] mag_a;
  logic [31:0] mag_c;
  logic [63:0] sq1_d;
  mat_t        mat_q;
  logic [63:0] sq1_q;
  logic        v1_q;

  assign mat_d = mat_t'(s_axis_tdata);
  assign mag_a = abs32(mat_d.a);
  assign mag_c = abs32(mat_d.c);
  assign sq1_d = 64'(mag_a) * 64'(mag_a) + 64'(mag_c) * 64'(mag_c);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mat_q <= mat_d;
      sq1_q <= sq1_d;
    end
  end

  // norm of the first column
  logic             vs1;
  logic [31:0]      n1;
  logic [MAT_W-1:0] mat_o_raw;
  mat_t             mat_o;

  qrgs_isqrt #(
    .IN_W   (64),
    .SIDE_W (MAT_W)
  ) u_sqrt_n1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v1_q),
    .rad_i   (sq1_q),
    .side_i  (mat_q),
    .valid_o (vs1),
    .root_o  (n1),
    .side_o  (mat_o_raw)
  );

  assign mat_o = mat_t'(mat_o_raw);

  // first unit vector
  d1_t             d1_in;
  logic            vd1;
  logic [QW-1:0]   q1x;
  logic [QW-1:0]   q1y;
  logic [D1_W-1:0] d1_raw;
  d1_t             d1_o;

  assign d1_in = '{sa: mat_o.a[31], sc: mat_o.c[31], b: mat_o.b, d: mat_o.d, n1: n1};

  qrgs_div #(
    .M_W    (32),
    .D_W    (32),
    .Q_W    (QW),
    .SIDE_W (D1_W)
  ) u_div_e1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vs1),
    .mx_i    (abs32(mat_o.a)),
    .my_i    (abs32(mat_o.c)),
    .den_i   (n1),
    .side_i  (d1_in),
    .valid_o (vd1),
    .qx_o    (q1x),
    .qy_o    (q1y),
    .side_o  (d1_raw)
  );

  assign d1_o = d1_t'(d1_raw);

  // stage 3: signed unit vector, zero column falls back to (1, 0)
  st3_t st3_d;
  st3_t st3_q;
  logic v3_q;

  always_comb begin
    st3_d.z1  = (d1_o.n1 == '0);
    st3_d.b   = d1_o.b;
    st3_d.d   = d1_o.d;
    st3_d.n1  = d1_o.n1;
    st3_d.e1x = d1_o.sa ? -EW'(q1x) : EW'(q1x);
    st3_d.e1y = d1_o.sc ? -EW'(q1y) : EW'(q1y);
    if (st3_d.z1) begin
      st3_d.e1x = ONE_E;
      st3_d.e1y = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st3_q <= st3_d;
    end
  end

  // stage 4: projection products
  logic signed [PW-1:0] pbx_q;
  logic signed [PW-1:0] pdy_q;
  st3_t                 st4_q;
  logic                 v4_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      pbx_q <= st3_q.b * st3_q.e1x;
      pdy_q <= st3_q.d * st3_q.e1y;
      st4_q <= st3_q;
    end
  end

  // stage 5: projection with floor shift
  logic signed [PW:0] sum5;
  st5_t               st5_q;
  logic               v5_q;

  assign sum5 = {pbx_q[PW-1], pbx_q} + {pdy_q[PW-1], pdy_q};

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st5_q <= '{uv: sum5[PW:FRAC_BITS], e1x: st4_q.e1x, e1y: st4_q.e1y,
                 b: st4_q.b, d: st4_q.d, n1: st4_q.n1, z1: st4_q.z1};
    end
  end

  // stage 6: projection times unit vector
  logic signed [MW-1:0] mx_q;
  logic signed [MW-1:0] my_q;
  st5_t                 st6_q;
  logic                 v6_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      mx_q  <= st5_q.uv * st5_q.e1x;
      my_q  <= st5_q.uv * st5_q.e1y;
      st6_q <= st5_q;
    end
  end

  // stage 7: residual, clipped to +-2^31, split into sign and magnitude
  logic signed [DW-1:0] ux_w;
  logic signed [DW-1:0] uy_w;
  logic signed [32:0]   ux_c;
  logic signed [32:0]   uy_c;
  logic [32:0]          ux_m;
  logic [32:0]          uy_m;
  st7_t                 st7_d;
  st7_t                 st7_q;
  logic                 v7_q;

  always_comb begin
    ux_w = DW'(st6_q.b) - DW'($signed(mx_q[MW-1:FRAC_BITS]));
    uy_w = DW'(st6_q.d) - DW'($signed(my_q[MW-1:FRAC_BITS]));
    if (ux_w > LIM_HI) begin
      ux_c = 33'(LIM_HI);
    end else if (ux_w < LIM_LO) begin
      ux_c = 33'(LIM_LO);
    end else begin
      ux_c = 33'(ux_w);
    end
    if (uy_w > LIM_HI) begin
      uy_c = 33'(LIM_HI);
    end else if (uy_w < LIM_LO) begin
      uy_c = 33'(LIM_LO);
    end else begin
      uy_c = 33'(uy_w);
    end
    ux_m      = ux_c[32] ? (~ux_c + 33'd1) : ux_c;
    uy_m      = uy_c[32] ? (~uy_c + 33'd1) : uy_c;
    st7_d.ax  = ux_m[31:0];
    st7_d.ay  = uy_m[31:0];
    st7_d.sx  = ux_c[32];
    st7_d.sy  = uy_c[32];
    st7_d.uv  = st6_q.uv;
    st7_d.e1x = st6_q.e1x;
    st7_d.e1y = st6_q.e1y;
    st7_d.n1  = st6_q.n1;
    st7_d.z1  = st6_q.z1;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st7_q <= st7_d;
    end
  end

  // stage 8: squared residual norm
  logic [63:0] sq2_q;
  st7_t        st8_q;
  logic        v8_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sq2_q <= 64'(st7_q.ax) * 64'(st7_q.ax) + 64'(st7_q.ay) * 64'(st7_q.ay);
      st8_q <= st7_q;
    end
  end

  // residual norm
  logic             vs2;
  logic [31:0]      n2;
  logic [ST7_W-1:0] st7_o_raw;
  st7_t             st7_o;

  qrgs_isqrt #(
    .IN_W   (64),
    .SIDE_W (ST7_W)
  ) u_sqrt_n2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v8_q),
    .rad_i   (sq2_q),
    .side_i  (st8_q),
    .valid_o (vs2),
    .root_o  (n2),
    .side_o  (st7_o_raw)
  );

  assign st7_o = st7_t'(st7_o_raw);

  // second unit vector
  d2_t             d2_in;
  logic            vd2;
  logic [QW-1:0]   q2x;
  logic [QW-1:0]   q2y;
  logic [D2_W-1:0] d2_raw;
  d2_t             d2_o;

  assign d2_in = '{sx: st7_o.sx, sy: st7_o.sy, uv: st7_o.uv, e1x: st7_o.e1x,
                   e1y: st7_o.e1y, n1: st7_o.n1, n2: n2, z1: st7_o.z1};

  qrgs_div #(
    .M_W    (32),
    .D_W    (32),
    .Q_W    (QW),
    .SIDE_W (D2_W)
  ) u_div_e2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (vs2),
    .mx_i    (st7_o.ax),
    .my_i    (st7_o.ay),
    .den_i   (n2),
    .side_i  (d2_in),
    .valid_o (vd2),
    .qx_o    (q2x),
    .qy_o    (q2y),
    .side_o  (d2_raw)
  );

  assign d2_o = d2_t'(d2_raw);

  // stage 9: q and r, saturation, status; dependent columns take e1 turned by +90 deg
  logic                 z2;
  logic signed [EW-1:0] e2x;
  logic signed [EW-1:0] e2y;
  res_t                 res_d;
  res_t                 res9_q;
  logic                 v9_q;

  always_comb begin
    z2  = (d2_o.n2 == '0);
    e2x = d2_o.sx ? -EW'(q2x) : EW'(q2x);
    e2y = d2_o.sy ? -EW'(q2y) : EW'(q2y);
    if (z2) begin
      e2x = -d2_o.e1y;
      e2y = d2_o.e1x;
    end
    res_d.q00 = 32'(d2_o.e1x);
    res_d.q10 = 32'(d2_o.e1y);
    res_d.q01 = 32'(e2x);
    res_d.q11 = 32'(e2y);
    res_d.r00 = d2_o.n1[31] ? 31'h7fffffff : d2_o.n1[30:0];
    res_d.r11 = d2_o.n2[31] ? 31'h7fffffff : d2_o.n2[30:0];
    if (d2_o.uv > I32_MAX) begin
      res_d.r01 = 32'(I32_MAX);
    end else if (d2_o.uv < I32_MIN) begin
      res_d.r01 = 32'(I32_MIN);
    end else begin
      res_d.r01 = 32'(d2_o.uv);
    end
    if (d2_o.z1) begin
      res_d.status = STATUS_COL0_ZERO;
    end else if (z2) begin
      res_d.status = STATUS_DEPENDENT;
    end else begin
      res_d.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      res9_q <= res_d;
    end
  end

  // stage 10: sine squared of the angle, 1.0^2 - c^2
  logic [31:0]      cm_w;
  logic [QW-1:0]    cm;
  logic [RAD_W-1:0] rad_q;
  res_t             res10_q;
  logic             v10_q;

  assign cm_w = abs32(res9_q.q00);
  assign cm   = cm_w[QW-1:0];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rad_q   <= ONE_SQ - RAD_W'(cm) * RAD_W'(cm);
      res10_q <= res9_q;
    end
  end

  // sine of the angle
  logic             vs3;
  logic [QW-1:0]    sn;
  logic [RES_W-1:0] res_s_raw;
  res_t             res_s;

  qrgs_isqrt #(
    .IN_W   (RAD_W),
    .SIDE_W (RES_W)
  ) u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v10_q),
    .rad_i   (rad_q),
    .side_i  (res10_q),
    .valid_o (vs3),
    .root_o  (sn),
    .side_o  (res_s_raw)
  );

  assign res_s = res_t'(res_s_raw);

  // stage 11: scale to Q2.30, negative cosine is turned by -90 deg first
  logic signed [CORDIC_W-1:0] xs;
  logic signed [CORDIC_W-1:0] ys;
  logic signed [CORDIC_W-1:0] x11_q;
  logic signed [CORDIC_W-1:0] y11_q;
  logic signed [CORDIC_W-1:0] z11_q;
  res_t                       res11_q;
  logic                       v11_q;

  assign xs = CORDIC_W'(res_s.q00) <<< SH;
  assign ys = CORDIC_W'(sn) <<< SH;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      if (res_s.q00[31]) begin
        x11_q <= ys;
        y11_q <= -xs;
        z11_q <= HALF_PI_Q30;
      end else begin
        x11_q <= xs;
        y11_q <= ys;
        z11_q <= '0;
      end
      res11_q <= res_s;
    end
  end

  // angle
  logic                       vc;
  logic signed [CORDIC_W-1:0] zc;
  logic [RES_W-1:0]           res_c_raw;
  res_t                       res_c;

  qrgs_cordic #(
    .SIDE_W (RES_W)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (v11_q),
    .x_i     (x11_q),
    .y_i     (y11_q),
    .z_i     (z11_q),
    .side_i  (res11_q),
    .valid_o (vc),
    .z_o     (zc),
    .side_o  (res_c_raw)
  );

  assign res_c = res_t'(res_c_raw);

  // output stage: clip to [0, pi], round to nearest, pick stretch
  logic signed [CORDIC_W-1:0] zcl;
  logic signed [CORDIC_W-1:0] zr;
  logic [25:0]                ang_d;
  logic [30:0]                str_d;
  res_t                       out_res_q;
  logic [25:0]                out_ang_q;
  logic [30:0]                out_str_q;

  always_comb begin
    if (zc[CORDIC_W-1]) begin
      zcl = '0;
    end else if (zc > PI_Q30) begin
      zcl = PI_Q30;
    end else begin
      zcl = zc;
    end
    zr    = (zcl + RND) >>> SH;
    ang_d = zr[25:0];
    str_d = (res_c.r00 >= thr_q) ? res_c.r00 : res_c.r11;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_res_q <= res_c;
      out_ang_q <= ang_d;
      out_str_q <= str_d;
    end
  end

  // valid bits of the top level stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
      v5_q      <= 1'b0;
      v6_q      <= 1'b0;
      v7_q      <= 1'b0;
      v8_q      <= 1'b0;
      v9_q      <= 1'b0;
      v10_q     <= 1'b0;
      v11_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q      <= s_axis_tvalid;
      v3_q      <= vd1;
      v4_q      <= v3_q;
      v5_q      <= v4_q;
      v6_q      <= v5_q;
      v7_q      <= v6_q;
      v8_q      <= v7_q;
      v9_q      <= vd2;
      v10_q     <= v9_q;
      v11_q     <= vs3;
      out_vld_q <= vc;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_res_q.status, out_str_q, out_ang_q,
                          out_res_q.r11, out_res_q.r01, out_res_q.r00,
                          out_res_q.q11, out_res_q.q10, out_res_q.q01, out_res_q.q00};

endmodule

[sim/qr_2x2_gram_schmidt_tb.sv]
`timescale 1ns / 100ps

module qr_2x2_gram_schmidt_tb;
  import qrgs_pkg::*;

  localparam int FRAC = 24;
  localparam longint ONE = 64'sd1 <<< FRAC;
  localparam int PIPE_DEPTH = 3 * FRAC + 108;
  localparam logic [31:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [31:0] NEG_MAX = 32'h8000_0000;

  // one decomposition result, fields as they leave the block
  typedef struct packed {
    logic signed [31:0] q00;
    logic signed [31:0] q01;
    logic signed [31:0] q10;
    logic signed [31:0] q11;
    logic [30:0]        r00;
    logic signed [31:0] r01;
    logic [30:0]        r11;
    logic [25:0]        angle;
    logic [30:0]        stretch;
    logic [1:0]         status;
  } qr_result_t;

  // golden decomposition plus the queue of results still owed by the block
  class qr_scoreboard;
    longint unsigned threshold;
    qr_result_t owed_q[$];
    int unsigned errors;

    function new();
      threshold = ONE;
      errors = 0;
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint unit_part(longint v, longint unsigned norm);
      longint unsigned m;
      m = (mag(v) << FRAC) / norm;
      if (m > ONE) m = ONE;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint clip_comp(longint v);
      longint lim;
      lim = 64'sd1 <<< 31;
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    // cordic vectoring on (c, sqrt(1-c^2)) in Q2.30
    function longint unsigned arc_cos(longint c);
      longint x, y, z, t, dx, dy, step_ang;
      longint unsigned cm;
      longint atan_tab [10];
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149};
      cm = mag(c);
      y = longint'(isqrt(longint'(ONE) * longint'(ONE) - cm * cm));
      x = c <<< (30 - FRAC);
      y = y <<< (30 - FRAC);
      z = 0;
      // left half plane: rotate by -pi/2 first
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = 64'sd1686629713;
      end
      for (int i = 0; i < 30; i++) begin
        step_ang = i < 10 ? atan_tab[i] : (64'sd1 <<< (30 - i));
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += step_ang;
        end else begin
          x -= dx; y += dy; z -= step_ang;
        end
      end
      if (z < 0) z = 0;
      if (z > 64'sd3373259426) z = 64'sd3373259426;
      z = (z + (64'sd1 <<< (30 - FRAC - 1))) >>> (30 - FRAC);
      return z;
    endfunction

    function qr_result_t decompose(logic [127:0] m);
      longint a, b, c, d, e1x, e1y, e2x, e2y, uv, ux, uy, r01;
      longint unsigned n1, n2, r00, r11;
      logic [1:0] st;
      qr_result_t r;
      a = longint'($signed(m[31:0]));
      b = longint'($signed(m[63:32]));
      c = longint'($signed(m[95:64]));
      d = longint'($signed(m[127:96]));
      st = STATUS_OK;
      n1 = isqrt(mag(a) * mag(a) + mag(c) * mag(c));
      if (n1 == 0) begin
        st = STATUS_COL0_ZERO;
        e1x = ONE;
        e1y = 0;
      end else begin
        e1x = unit_part(a, n1);
        e1y = unit_part(c, n1);
      end
      uv = (b * e1x + d * e1y) >>> FRAC;
      ux = clip_comp(b - ((uv * e1x) >>> FRAC));
      uy = clip_comp(d - ((uv * e1y) >>> FRAC));
      n2 = isqrt(mag(ux) * mag(ux) + mag(uy) * mag(uy));
      if (n2 == 0) begin
        if (st == STATUS_OK) st = STATUS_DEPENDENT;
        e2x = -e1y;
        e2y = e1x;
      end else begin
        e2x = unit_part(ux, n2);
        e2y = unit_part(uy, n2);
      end
      r00 = n1 > POS_MAX ? POS_MAX : n1;
      r11 = n2 > POS_MAX ? POS_MAX : n2;
      r01 = uv > 64'sh7fff_ffff ? 64'sh7fff_ffff
          : (uv < -64'sh8000_0000 ? -64'sh8000_0000 : uv);
      r.q00 = e1x[31:0];
      r.q01 = e2x[31:0];
      r.q10 = e1y[31:0];
      r.q11 = e2y[31:0];
      r.r00 = r00[30:0];
      r.r01 = r01[31:0];
      r.r11 = r11[30:0];
      r.angle = 26'(arc_cos(e1x));
      r.stretch = r00 >= threshold ? r00[30:0] : r11[30:0];
      r.status = st;
      return r;
    endfunction

    function void note_request(logic [127:0] m);
      owed_q = {owed_q, decompose(m)};
    endfunction

    function void cmp(string name, longint want, longint got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [287:0] t);
      qr_result_t w;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: %h", t);
        errors++;
        return;
      end
      w = owed_q.pop_front();
      cmp("q_00", w.q00, $signed(t[31:0]));
      cmp("q_01", w.q01, $signed(t[63:32]));
      cmp("q_10", w.q10, $signed(t[95:64]));
      cmp("q_11", w.q11, $signed(t[127:96]));
      cmp("r_00", w.r00, t[158:128]);
      cmp("r_01", w.r01, $signed(t[190:159]));
      cmp("r_11", w.r11, t[221:191]);
      cmp("rotation_angle", w.angle, t[247:222]);
      cmp("stretch", w.stretch, t[278:248]);
      cmp("status", w.status, t[280:279]);
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [287:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [30:0]  cfg_wdata_i;

  qr_scoreboard sb;
  bit calm;  // no idling on either side in the closing stretch

  qr_2x2_gram_schmidt #(.FRAC_BITS(FRAC)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // one matrix request, with an occasional idle burst ahead of it
  task automatic send_matrix(logic [31:0] a00, logic [31:0] a01,
                             logic [31:0] a10, logic [31:0] a11);
    logic [127:0] m;
    m = {a11, a10, a01, a00};
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= m;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(m);
  endtask

  // entry with a mix of full range, small, and edge values
  function automatic logic [31:0] pick_entry();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(0, 1 << 27) - (1 << 26);
      4: v = $urandom_range(0, 1) ? ONE[31:0] : -ONE[31:0];
      default: begin
        case ($urandom_range(0, 4))
          0: v = POS_MAX;
          1: v = NEG_MAX;
          2: v = 32'hffff_ffff;
          3: v = 32'd1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random();
    logic [31:0] a00, a01, a10, a11;
    int k;
    a00 = pick_entry();
    a01 = pick_entry();
    a10 = pick_entry();
    a11 = pick_entry();
    case ($urandom_range(0, 7))
      // second column a multiple of the first: dependent columns
      0: begin
        a00 = $urandom_range(0, 1 << 24) - (1 << 23);
        a10 = $urandom_range(0, 1 << 24) - (1 << 23);
        k = $urandom_range(0, 8) - 4;
        a01 = a00 * k;
        a11 = a10 * k;
      end
      // zero first column
      1: begin
        a00 = '0;
        a10 = '0;
      end
      default: ;
    endcase
    send_matrix(a00, a01, a10, a11);
  endtask

  task automatic wait_drained();
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    // every accepted request has been checked; the wait below still catches stray results
    repeat (PIPE_DEPTH + 20) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [30:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.threshold = v;
  endtask

  task automatic directed_matrices();
    send_matrix(ONE[31:0], '0, '0, ONE[31:0]);             // identity
    send_matrix('0, '0, '0, '0);                           // both columns zero
    send_matrix('0, 3 * ONE[31:0], '0, -ONE[31:0]);        // first column zero
    send_matrix('0, NEG_MAX, '0, NEG_MAX);
    send_matrix(ONE[31:0], 2 * ONE[31:0], ONE[31:0], 2 * ONE[31:0]);  // dependent
    send_matrix(-ONE[31:0], '0, '0, ONE[31:0]);            // angle of pi
    send_matrix(-ONE[31:0], ONE[31:0], ONE[31:0], ONE[31:0]);
    send_matrix('0, '0, ONE[31:0], '0);                    // e1 straight up
    send_matrix(POS_MAX, POS_MAX, POS_MAX, POS_MAX);
    send_matrix(NEG_MAX, NEG_MAX, NEG_MAX, NEG_MAX);
    send_matrix(NEG_MAX, POS_MAX, POS_MAX, NEG_MAX);
    send_matrix(POS_MAX, NEG_MAX, NEG_MAX, POS_MAX);
    send_matrix(NEG_MAX, '0, NEG_MAX, '0);
    send_matrix(32'd1, 32'd1, 32'hffff_ffff, 32'd1);
    send_matrix(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_matrix(ONE[31:0] >> 1, 2 * ONE[31:0], -(ONE[31:0] >> 1), 32'd7);
    send_matrix(32'hffff_ffff, 32'hffff_ffff, '0, '0);
  endtask

  // output side backpressure in bursts
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    logic [30:0] phase_thr [5];
    sb = new();
    calm = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // first phase runs on the reset threshold of 1.0
    phase_thr = '{31'(ONE), 31'd0, 31'h7fff_ffff, 31'($urandom), 31'(3 * ONE)};
    for (int p = 0; p < 5; p++) begin
      if (p > 0) begin
        wait_drained();
        write_threshold(phase_thr[p]);
      end
      if (p == 4) calm = 1'b1;
      if (p == 0) directed_matrices();
      for (int n = 0; n < 87; n++) send_random();
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
